FILE: rtl/dual_quadrature_tone_generator_assert.svh
// Assertion macros shared by the tone generator RTL.
// Both macros expect i_clk and i_rst_n in scope.
`ifndef DUAL_QUADRATURE_TONE_GENERATOR_ASSERT_SVH
`define DUAL_QUADRATURE_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define DQTG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DQTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/dqtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqtg_pkg;

    localparam int XY_W    = 20;
    localparam int Z_W     = 33;
    localparam int AMP_W   = 11;
    localparam int TW_W    = 32;
    localparam int THETA_W = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 20'sd39797;

    typedef enum logic [1:0] {
        CFG_TW_ONE = 2'd0,
        CFG_TW_TWO = 2'd1,
        CFG_AMP    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_rot;

    typedef struct packed {
        t_rot one;
        t_rot two;
    } t_cell;

    function automatic logic [THETA_W-1:0] arc_angle(input int unsigned idx);
        case (idx)
            0:       arc_angle = 32'h20000000;
            1:       arc_angle = 32'h12E4051E;
            2:       arc_angle = 32'h09FB385B;
            3:       arc_angle = 32'h051111D4;
            4:       arc_angle = 32'h028B0D43;
            5:       arc_angle = 32'h0145D7E1;
            6:       arc_angle = 32'h00A2F61E;
            7:       arc_angle = 32'h00517C55;
            8:       arc_angle = 32'h0028BE53;
            9:       arc_angle = 32'h00145F2F;
            10:      arc_angle = 32'h000A2F98;
            11:      arc_angle = 32'h000517CC;
            12:      arc_angle = 32'h00028BE6;
            13:      arc_angle = 32'h000145F3;
            14:      arc_angle = 32'h0000A2FA;
            15:      arc_angle = 32'h0000517D;
            16:      arc_angle = 32'h000028BE;
            17:      arc_angle = 32'h0000145F;
            18:      arc_angle = 32'h00000A30;
            19:      arc_angle = 32'h00000518;
            20:      arc_angle = 32'h0000028C;
            21:      arc_angle = 32'h00000146;
            22:      arc_angle = 32'h000000A3;
            23:      arc_angle = 32'h00000051;
            default: arc_angle = '0;
        endcase
    endfunction

    function automatic logic signed [Z_W-1:0] arc_z(input int unsigned idx);
        arc_z = $signed({1'b0, arc_angle(idx)});
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dqtg_cell.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dual_quadrature_tone_generator_assert.svh"

module dqtg_cell #(
    parameter int STAGE = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire dqtg_pkg::t_cell i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output dqtg_pkg::t_cell      o_data
);

    localparam logic signed [dqtg_pkg::Z_W-1:0] ARC = dqtg_pkg::arc_z(STAGE);

    logic            r_valid;
    dqtg_pkg::t_cell r_data;
    dqtg_pkg::t_cell n_data;

    function automatic dqtg_pkg::t_rot rotate(input dqtg_pkg::t_rot r);
        logic signed [dqtg_pkg::XY_W-1:0] xs;
        logic signed [dqtg_pkg::XY_W-1:0] ys;
        xs = $signed(r.x) >>> STAGE;
        ys = $signed(r.y) >>> STAGE;
        rotate = r;
        if (!r.z[dqtg_pkg::Z_W-1]) begin
            rotate.x = r.x - ys;
            rotate.y = r.y + xs;
            rotate.z = r.z - ARC;
        end else begin
            rotate.x = r.x + ys;
            rotate.y = r.y - xs;
            rotate.z = r.z + ARC;
        end
    endfunction

    always_comb begin
        n_data.one = rotate(i_data.one);
        n_data.two = rotate(i_data.two);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    `DQTG_ASSERT_NEXT(a_stall_hold, r_valid && !i_ready, r_valid && $stable(r_data))

endmodule

`default_nettype wire

FILE: rtl/dqtg_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module dqtg_scale #(
    parameter int OUT_BITS = 12
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire dqtg_pkg::t_cell         i_data,
    input  wire [dqtg_pkg::AMP_W-1:0]    i_amplitude,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [OUT_BITS-1:0]   o_one_i,
    output logic signed [OUT_BITS-1:0]   o_one_q,
    output logic signed [OUT_BITS-1:0]   o_two_i,
    output logic signed [OUT_BITS-1:0]   o_two_q,
    output logic signed [OUT_BITS:0]     o_diff_i,
    output logic signed [OUT_BITS:0]     o_diff_q
);

    localparam int P_W = dqtg_pkg::XY_W + dqtg_pkg::AMP_W + 1;
    localparam int T_W = P_W - 16;
    localparam int HI  = 2 ** (OUT_BITS - 1) - 1;
    localparam int LO  = -HI - 1;

    logic                        r_a_valid;
    logic signed [P_W-1:0]       r_prod [4];
    logic signed [P_W-1:0]       n_prod [4];
    logic                        r_b_valid;
    logic signed [OUT_BITS-1:0]  n_out  [4];
    logic                        a_ready;
    logic                        b_ready;

    function automatic logic signed [P_W-1:0] mul_amp(
        input logic signed [dqtg_pkg::XY_W-1:0] v,
        input logic                             flip,
        input logic [dqtg_pkg::AMP_W-1:0]       amp
    );
        logic signed [dqtg_pkg::XY_W-1:0] s;
        logic signed [dqtg_pkg::AMP_W:0]  a;
        s = flip ? -v : v;
        a = $signed({1'b0, amp});
        mul_amp = P_W'(s) * P_W'(a);
    endfunction

    // truncate toward zero, then clamp
    function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] pr;
        logic signed [T_W-1:0] t;
        pr = p + $signed({{(P_W-16){1'b0}}, {16{p[P_W-1]}}});
        t  = pr[P_W-1:16];
        if (t > HI) begin
            sat = OUT_BITS'(HI);
        end else if (t < LO) begin
            sat = OUT_BITS'(LO);
        end else begin
            sat = OUT_BITS'(t);
        end
    endfunction

    always_comb begin
        n_prod[0] = mul_amp(i_data.one.x, i_data.one.flip, i_amplitude);
        n_prod[1] = mul_amp(i_data.one.y, i_data.one.flip, i_amplitude);
        n_prod[2] = mul_amp(i_data.two.x, i_data.two.flip, i_amplitude);
        n_prod[3] = mul_amp(i_data.two.y, i_data.two.flip, i_amplitude);
        for (int k = 0; k < 4; k++) begin
            n_out[k] = sat(r_prod[k]);
        end
    end

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
        if (r_a_valid && b_ready) begin
            o_one_i  <= n_out[0];
            o_one_q  <= n_out[1];
            o_two_i  <= n_out[2];
            o_two_q  <= n_out[3];
            o_diff_i <= $signed({n_out[2][OUT_BITS-1], n_out[2]})
                      - $signed({n_out[0][OUT_BITS-1], n_out[0]});
            o_diff_q <= $signed({n_out[3][OUT_BITS-1], n_out[3]})
                      - $signed({n_out[1][OUT_BITS-1], n_out[1]});
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dual_quadrature_tone_generator.sv
// Pipeline: a result beat passes one register per CORDIC cell, one for the amplitude
// multiply and one for the output. Throughput: one beat per cycle while i_m_tready does
// not stall the output; each CORDIC cell and back-end stage is fully pipelined.
// Reset (synchronous, active low): phases cleared, tuning words and amplitude to defaults,
// pipeline emptied.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_quadrature_tone_generator_assert.svh"

module dual_quadrature_tone_generator #(
    parameter int PHASE_BITS    = 32,
    parameter int OUT_BITS      = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire  [7:0]                              i_s_tdata,  // restart
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    // tone_one_i, tone_one_q, tone_two_i, tone_two_q, diff_i, diff_q, zero pad
    output logic [((6*OUT_BITS+2+7)/8)*8-1:0]       o_m_tdata,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire  [1:0]                              i_cfg_index,
    input  wire  [31:0]                             i_cfg_data
);

    localparam int DATA_W  = 6 * OUT_BITS + 2;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int UP_SH   = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int DOWN_SH = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

    logic [dqtg_pkg::TW_W-1:0]    r_tw_one;
    logic [dqtg_pkg::TW_W-1:0]    r_tw_two;
    logic [dqtg_pkg::AMP_W-1:0]   r_amp;
    logic [PHASE_BITS-1:0]        r_phase_one;
    logic [PHASE_BITS-1:0]        r_phase_two;
    logic [PHASE_BITS-1:0]        n_phase_one;
    logic [PHASE_BITS-1:0]        n_phase_two;
    logic [PHASE_BITS-1:0]        sel_one;
    logic [PHASE_BITS-1:0]        sel_two;
    logic [PHASE_BITS-1:0]        step_one;
    logic [PHASE_BITS-1:0]        step_two;
    logic [dqtg_pkg::THETA_W-1:0] theta_one;
    logic [dqtg_pkg::THETA_W-1:0] theta_two;
    logic                         s_acc;

    logic [CORDIC_STAGES:0]       w_valid;
    logic [CORDIC_STAGES:0]       w_ready;
    dqtg_pkg::t_cell              w_data [CORDIC_STAGES+1];

    logic signed [OUT_BITS-1:0]   one_i;
    logic signed [OUT_BITS-1:0]   one_q;
    logic signed [OUT_BITS-1:0]   two_i;
    logic signed [OUT_BITS-1:0]   two_q;
    logic signed [OUT_BITS:0]     diff_i;
    logic signed [OUT_BITS:0]     diff_q;

    // fold into +/- quarter turn, record the half-turn flip
    function automatic dqtg_pkg::t_rot start_rot(input logic [dqtg_pkg::THETA_W-1:0] th);
        logic                         fl;
        logic [dqtg_pkg::THETA_W-1:0] zf;
        fl = th[31] ^ th[30];
        zf = fl ? {~th[31], th[30:0]} : th;
        start_rot.x    = dqtg_pkg::CORDIC_GAIN;
        start_rot.y    = '0;
        start_rot.z    = $signed({zf[31], zf});
        start_rot.flip = fl;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;

    assign sel_one     = i_s_tdata[0] ? '0 : r_phase_one;
    assign sel_two     = i_s_tdata[0] ? '0 : r_phase_two;
    assign n_phase_one = sel_one + step_one;
    assign n_phase_two = sel_two + step_two;

    generate
        if (PHASE_BITS >= 32) begin : g_wide
            assign theta_one = sel_one[PHASE_BITS-1 -: 32];
            assign theta_two = sel_two[PHASE_BITS-1 -: 32];
            assign step_one  = PHASE_BITS'(r_tw_one) << UP_SH;
            assign step_two  = PHASE_BITS'(r_tw_two) << UP_SH;
        end else begin : g_narrow
            assign theta_one = 32'(sel_one) << DOWN_SH;
            assign theta_two = 32'(sel_two) << DOWN_SH;
            assign step_one  = PHASE_BITS'(r_tw_one >> DOWN_SH);
            assign step_two  = PHASE_BITS'(r_tw_two >> DOWN_SH);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw_one    <= 32'd429496730;
            r_tw_two    <= 32'd858993459;
            r_amp       <= 11'd724;
            r_phase_one <= '0;
            r_phase_two <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    dqtg_pkg::CFG_TW_ONE: r_tw_one <= i_cfg_data;
                    dqtg_pkg::CFG_TW_TWO: r_tw_two <= i_cfg_data;
                    dqtg_pkg::CFG_AMP:    r_amp    <= i_cfg_data[dqtg_pkg::AMP_W-1:0];
                    default:              ;
                endcase
            end
            if (s_acc) begin
                r_phase_one <= n_phase_one;
                r_phase_two <= n_phase_two;
            end
        end
    end

    assign w_valid[0]    = i_s_tvalid;
    assign o_s_tready    = w_ready[0];
    assign w_data[0].one = start_rot(theta_one);
    assign w_data[0].two = start_rot(theta_two);

    generate
        for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
            dqtg_cell #(
                .STAGE (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_data  (w_data[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_data  (w_data[g+1])
            );
        end
    endgenerate

    dqtg_scale #(
        .OUT_BITS (OUT_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[CORDIC_STAGES]),
        .o_ready     (w_ready[CORDIC_STAGES]),
        .i_data      (w_data[CORDIC_STAGES]),
        .i_amplitude (r_amp),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_one_i     (one_i),
        .o_one_q     (one_q),
        .o_two_i     (two_i),
        .o_two_q     (two_q),
        .o_diff_i    (diff_i),
        .o_diff_q    (diff_q)
    );

    assign o_m_tdata = TDATA_W'({diff_q, diff_i, two_q, two_i, one_q, one_i});

    `DQTG_ASSERT_NEXT(a_restart_clears, s_acc && i_s_tdata[0],
        r_phase_one == $past(step_one) && r_phase_two == $past(step_two))
    `DQTG_ASSERT_NEXT(a_phase_hold, !s_acc, $stable(r_phase_one) && $stable(r_phase_two))

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int OUT_W  = 12;
    localparam int DIFF_W = OUT_W + 1;
    localparam int M_W    = ((6*OUT_W+2+7)/8)*8;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 2;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [1:0] REG_TW_ONE    = dqtg_pkg::CFG_TW_ONE;
    localparam logic [1:0] REG_TW_TWO    = dqtg_pkg::CFG_TW_TWO;
    localparam logic [1:0] REG_AMPLITUDE = dqtg_pkg::CFG_AMP;
    localparam logic [1:0] REG_UNUSED    = 2'd3;

    localparam longint GAIN_Q16     = 64'sd39797;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint FULL_TURN    = 64'sd4294967296;
    localparam longint OUT_MAX      = (64'sd1 <<< (OUT_W-1)) - 1;
    localparam longint OUT_MIN      = -OUT_MAX - 1;

    typedef struct packed {
        logic signed [OUT_W-1:0]  one_i;
        logic signed [OUT_W-1:0]  one_q;
        logic signed [OUT_W-1:0]  two_i;
        logic signed [OUT_W-1:0]  two_q;
        logic signed [DIFF_W-1:0] diff_i;
        logic signed [DIFF_W-1:0] diff_q;
    } t_tone_sample;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_s_tvalid  = 1'b0;
    wire             o_s_tready;
    logic [7:0]      i_s_tdata   = 8'd0;   // restart, zero pad
    wire             o_m_tvalid;
    logic            i_m_tready  = 1'b0;
    // tone_one_i, tone_one_q, tone_two_i, tone_two_q, diff_i, diff_q, zero pad
    wire  [M_W-1:0]  o_m_tdata;
    logic            i_cfg_valid = 1'b0;
    wire             o_cfg_ready;
    logic [1:0]      i_cfg_index = 2'd0;
    logic [31:0]     i_cfg_data  = 32'd0;

    logic            restart_queue[$];
    t_tone_sample    pending_tones[$];

    logic [31:0]     tw_one_model = 32'd429496730;
    logic [31:0]     tw_two_model = 32'd858993459;
    logic [10:0]     amp_model    = 11'd724;
    logic [31:0]     phase_one    = 32'd0;
    logic [31:0]     phase_two    = 32'd0;

    bit              src_idle_on  = 1'b1;
    bit              sink_idle_on = 1'b1;
    int unsigned     src_gap      = 0;
    int unsigned     sink_stall   = 0;
    int              quiet_cycles = 0;
    int              mismatches   = 0;

    dual_quadrature_tone_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint arc_step(input int k);
        case (k)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2FA;
            15:      return 64'h0000517D;
            default: return 64'h0;
        endcase
    endfunction

    // amplitude scaling, truncation toward zero, clamp to the output range
    function automatic logic signed [OUT_W-1:0] scale_to_out(input longint v, input longint amp);
        longint p;
        longint t;
        p = v * amp;
        t = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
        if (t > OUT_MAX) t = OUT_MAX;
        if (t < OUT_MIN) t = OUT_MIN;
        return OUT_W'(t);
    endfunction

    function automatic void rotate_phase(input logic [31:0] ph, input longint amp,
                                         output logic signed [OUT_W-1:0] c,
                                         output logic signed [OUT_W-1:0] s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'({32'd0, ph});
        x = GAIN_Q16;
        y = 0;
        flip = 1'b0;
        if (z >= HALF_TURN) z -= FULL_TURN;
        // fold the back half plane onto the front, negate afterwards
        if (z >= QUARTER_TURN || z < -QUARTER_TURN) begin
            flip = 1'b1;
            z += (z >= 0) ? -HALF_TURN : HALF_TURN;
        end
        for (int k = 0; k < STAGES; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z -= arc_step(k);
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z += arc_step(k);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = scale_to_out(x, amp);
        s = scale_to_out(y, amp);
    endfunction

    function automatic t_tone_sample predict_tones(input logic restart);
        t_tone_sample t;
        longint       amp;
        amp = longint'({53'd0, amp_model});
        if (restart) begin
            phase_one = 32'd0;
            phase_two = 32'd0;
        end
        rotate_phase(phase_one, amp, t.one_i, t.one_q);
        rotate_phase(phase_two, amp, t.two_i, t.two_q);
        t.diff_i = DIFF_W'(int'($signed(t.two_i)) - int'($signed(t.one_i)));
        t.diff_q = DIFF_W'(int'($signed(t.two_q)) - int'($signed(t.one_q)));
        phase_one = phase_one + tw_one_model;
        phase_two = phase_two + tw_two_model;
        return t;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // slave side: present queued restart beats, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'd0;
            src_gap    <= 0;
            phase_one  = 32'd0;
            phase_two  = 32'd0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_tones.push_back(predict_tones(i_s_tdata[0]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap    <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (restart_queue.size() != 0) begin
                    i_s_tdata  <= {7'd0, restart_queue.pop_front()};
                    i_s_tvalid <= 1'b1;
                    src_gap    <= src_idle_on ? pick_gap() : 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side: random stalls, compare each beat with the oldest prediction
    always @(posedge i_clk) begin : sink_side
        t_tone_sample want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_tones.size() == 0) begin
                    $error("result beat with no sample expected");
                    mismatches++;
                end else begin
                    want = pending_tones.pop_front();
                    check_field("tone_one_i", int'($signed(want.one_i)),
                                int'($signed(o_m_tdata[11:0])));
                    check_field("tone_one_q", int'($signed(want.one_q)),
                                int'($signed(o_m_tdata[23:12])));
                    check_field("tone_two_i", int'($signed(want.two_i)),
                                int'($signed(o_m_tdata[35:24])));
                    check_field("tone_two_q", int'($signed(want.two_q)),
                                int'($signed(o_m_tdata[47:36])));
                    check_field("diff_i", int'($signed(want.diff_i)),
                                int'($signed(o_m_tdata[60:48])));
                    check_field("diff_q", int'($signed(want.diff_q)),
                                int'($signed(o_m_tdata[73:61])));
                end
            end
            if (sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0) sink_stall <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tw_one_model <= 32'd429496730;
            tw_two_model <= 32'd858993459;
            amp_model    <= 11'd724;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TW_ONE:    tw_one_model <= i_cfg_data;
                REG_TW_TWO:    tw_two_model <= i_cfg_data;
                REG_AMPLITUDE: amp_model    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pattern(input int n, input logic [31:0] bits);
        for (int k = 0; k < n; k++) restart_queue.push_back(bits[k]);
    endtask

    task automatic wait_drained();
        while (restart_queue.size() != 0 || i_s_tvalid || pending_tones.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 32'hFFFF);
            3:       return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] word;
        logic [10:0] amp;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, restart at the start and again mid-run
        push_pattern(12, 32'b0100_0000_0001);
        wait_drained();

        // unused index must not disturb anything; extreme words, full amplitude
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_TW_ONE, 32'd0);
        write_reg(REG_TW_TWO, 32'hFFFF_FFFF);
        write_reg(REG_AMPLITUDE, 32'h0000_07FF);
        push_pattern(4, 32'b0001);
        wait_drained();

        // exact and near quarter-turn steps hit the fold boundaries
        write_reg(REG_TW_ONE, 32'h4000_0000);
        write_reg(REG_TW_TWO, 32'h3FFF_FFFF);
        push_pattern(6, 32'b00_0001);
        wait_drained();

        // zero amplitude, half-turn steps, junk above the amplitude field
        write_reg(REG_AMPLITUDE, 32'hFFFF_F800);
        write_reg(REG_TW_ONE, 32'h8000_0000);
        write_reg(REG_TW_TWO, 32'h7FFF_FFFF);
        push_pattern(3, 32'b100);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            src_idle_on  = ($urandom_range(0, 2) != 0);
            sink_idle_on = ($urandom_range(0, 2) != 0);
            write_reg(REG_TW_ONE, pick_word());
            write_reg(REG_TW_TWO, pick_word());
            case ($urandom_range(0, 3))
                0:       amp = 11'd0;
                1:       amp = 11'h7FF;
                default: amp = 11'($urandom);
            endcase
            word = $urandom;
            word[10:0] = amp;
            write_reg(REG_AMPLITUDE, word);
            if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
            for (int k = 0; k < 75; k++) restart_queue.push_back($urandom_range(0, 12) == 0);
            wait_drained();
        end

        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/dqtg_pkg.sv
rtl/dqtg_cell.sv
rtl/dqtg_scale.sv
rtl/dual_quadrature_tone_generator.sv
dv/testbench.sv
